// ===== rtl/ctc_pkg.sv =====
// Shared types, constants and the month length table of the calendar tick clock.
package ctc_pkg;

   localparam logic       KIND_TICK           = 1'b0;
   localparam logic       KIND_LOAD           = 1'b1;

   localparam logic [6:0] HUND_LAST           = 7'd99;
   localparam logic [6:0] SEC_PER_MIN         = 7'd60;
   localparam logic [6:0] MIN_PER_HOUR        = 7'd60;
   localparam logic [5:0] HOURS_PER_DAY       = 6'd24;
   localparam logic [4:0] MONTH_LAST          = 5'd12;
   localparam logic [3:0] MONTH_FIRST         = 4'd1;
   localparam logic [4:0] DAYS_SHORT          = 5'd28;
   localparam logic [4:0] DAYS_LONG           = 5'd31;
   localparam logic [4:0] DAYS_NORMAL         = 5'd30;
   localparam logic [7:0] SAVE_INTERVAL_RESET = 8'd100;

   typedef struct packed {
      logic        kind;
      logic [6:0]  load_hundredths;
      logic [5:0]  load_second;
      logic [5:0]  load_minute;
      logic [4:0]  load_hour;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [15:0] load_year;
   } req_type;

   typedef struct packed {
      logic [6:0]  hundredths;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic        save_request;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  hundredths;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
   } time_type;

   // Invalid month codes count as 30-day months.
   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month) inside
         4'd2: begin
            len = DAYS_SHORT;
         end
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            len = DAYS_LONG;
         end
         default: begin
            len = DAYS_NORMAL;
         end
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/calendar_tick_clock.sv =====
// Calendar tick clock: hundredths through years with a periodic save request.
//
// Usage:
//   req_* carries one transaction per tick (kind 0) or a time load (kind 1).
//   rsp_* returns exactly one transaction per request: the time after the
//   step and save_request, set when the save countdown expired on that tick.
//   csr_write_enable / csr_write_data write save_interval, used at the next
//   countdown reload.
// Timing:
//   A request is registered at acceptance and processed into the result
//   register, which drives rsp_valid, once that register is empty or its
//   result is taken. The calendar step is one compare-and-increment cascade,
//   so one transaction is taken every cycle while rsp_stall is low.
// Reset:
//   Time clears to zero with month 1; interval and countdown load 100.
// Stall:
//   While rsp_stall holds a result, one more request is still taken into
//   the input register; req_stall rises only when both registers are full.
module calendar_tick_clock (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ctc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ctc_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);
   import ctc_pkg::*;

   logic     in_valid_ff;
   logic     in_valid_in;
   req_type  in_req_ff;
   req_type  in_req_in;
   logic     out_valid_ff;
   logic     out_valid_in;
   rsp_type  out_rsp_ff;
   rsp_type  out_rsp_in;
   time_type time_ff;
   time_type time_in;
   time_type time_tick;
   time_type time_load;
   logic     accept_in;
   logic     advance;
   logic     is_tick;
   logic     save_request;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept_in = req_valid && !req_stall;
   assign is_tick   = advance && (in_req_ff.kind == KIND_TICK);

   assign in_valid_in = accept_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_req_in   = accept_in ? req_data : in_req_ff;

   ctc_calendar_next u_next (
      .cur (time_ff),
      .nxt (time_tick)
   );

   ctc_save_timer u_save (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tick             (is_tick),
      .save_request     (save_request)
   );

   always_comb begin
      time_load.hundredths = in_req_ff.load_hundredths;
      time_load.second     = in_req_ff.load_second;
      time_load.minute     = in_req_ff.load_minute;
      time_load.hour       = in_req_ff.load_hour;
      time_load.day        = in_req_ff.load_day;
      time_load.month      = in_req_ff.load_month;
      time_load.year       = in_req_ff.load_year;
   end

   always_comb begin
      time_in = time_ff;
      if (advance) begin
         time_in = (in_req_ff.kind == KIND_LOAD) ? time_load : time_tick;
      end
   end

   always_comb begin
      out_rsp_in = out_rsp_ff;
      if (advance) begin
         out_rsp_in.hundredths   = time_in.hundredths;
         out_rsp_in.second       = time_in.second;
         out_rsp_in.minute       = time_in.minute;
         out_rsp_in.hour         = time_in.hour;
         out_rsp_in.day          = time_in.day;
         out_rsp_in.month        = time_in.month;
         out_rsp_in.year         = time_in.year;
         out_rsp_in.save_request = is_tick && save_request;
      end
   end

   // hold the result while stalled, drop it once taken
   assign out_valid_in = advance ? 1'b1 :
                         ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         time_ff         <= {7'd0, 6'd0, 6'd0, 5'd0, 5'd0, MONTH_FIRST, 16'd0};
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         time_ff         <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

// ===== rtl/ctc_calendar_next.sv =====
// Next calendar time for one tick: cascaded compare-and-increment of all fields.
module ctc_calendar_next (
   input  ctc_pkg::time_type cur,
   output ctc_pkg::time_type nxt
);
   import ctc_pkg::*;

   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic [5:0] day_inc;
   logic [4:0] month_inc;
   logic       hund_carry;
   logic       sec_carry;
   logic       min_carry;
   logic       hour_carry;
   logic       day_carry;
   logic       month_carry;

   assign sec_inc   = {1'b0, cur.second} + 7'd1;
   assign min_inc   = {1'b0, cur.minute} + 7'd1;
   assign hour_inc  = {1'b0, cur.hour} + 6'd1;
   assign day_inc   = {1'b0, cur.day} + 6'd1;
   assign month_inc = {1'b0, cur.month} + 5'd1;

   // Out-of-range values wrap with a carry just like the last legal value.
   assign hund_carry  = (cur.hundredths >= HUND_LAST);
   assign sec_carry   = hund_carry && (sec_inc >= SEC_PER_MIN);
   assign min_carry   = sec_carry && (min_inc >= MIN_PER_HOUR);
   assign hour_carry  = min_carry && (hour_inc >= HOURS_PER_DAY);
   assign day_carry   = hour_carry && (day_inc >= {1'b0, month_length(cur.month)});
   assign month_carry = day_carry && (month_inc > MONTH_LAST);

   always_comb begin
      nxt = cur;
      nxt.hundredths = hund_carry ? 7'd0 : (cur.hundredths + 7'd1);
      if (hund_carry) begin
         nxt.second = sec_carry ? 6'd0 : sec_inc[5:0];
      end
      if (sec_carry) begin
         nxt.minute = min_carry ? 6'd0 : min_inc[5:0];
      end
      if (min_carry) begin
         nxt.hour = hour_carry ? 5'd0 : hour_inc[4:0];
      end
      if (hour_carry) begin
         nxt.day = day_carry ? 5'd0 : day_inc[4:0];
      end
      if (day_carry) begin
         nxt.month = month_carry ? MONTH_FIRST : month_inc[3:0];
      end
      if (month_carry) begin
         nxt.year = cur.year + 16'd1;
      end
   end

endmodule

// ===== rtl/ctc_save_timer.sv =====
// Save interval register and the save countdown that flags periodic save requests.
module ctc_save_timer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       tick,
   output logic       save_request
);
   import ctc_pkg::*;

   logic [7:0] interval_ff;
   logic [7:0] interval_in;
   logic [7:0] countdown_ff;
   logic [7:0] countdown_in;
   logic [7:0] countdown_dec;

   assign countdown_dec = countdown_ff - 8'd1;
   assign save_request  = (countdown_dec == 8'd0);
   assign interval_in   = csr_write_enable ? csr_write_data : interval_ff;

   always_comb begin
      countdown_in = countdown_ff;
      if (tick) begin
         // reload on expiry; a zero interval wraps to 255 on the next tick
         countdown_in = save_request ? interval_ff : countdown_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= SAVE_INTERVAL_RESET;
         countdown_ff <= SAVE_INTERVAL_RESET;
      end else begin
         interval_ff  <= interval_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

// ===== test/tb_calendar_tick_clock.sv =====
// Testbench for calendar_tick_clock: queued ticks and loads checked against a local calendar model.
`timescale 1ns / 1ps

module tb_calendar_tick_clock;
   import ctc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_data         = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = 8'd0;

   // Local calendar state and save countdown.
   time_type   clock_now   = {7'd0, 6'd0, 6'd0, 5'd0, 5'd0, MONTH_FIRST, 16'd0};
   logic [7:0] save_left   = SAVE_INTERVAL_RESET;
   logic [7:0] save_period = SAVE_INTERVAL_RESET;

   req_type    pending_reqs[$];
   rsp_type    expected_times[$];

   int         cycle_count = 0;
   int         mismatches  = 0;
   int         send_gap    = 0;
   int         stall_gap   = 0;
   int         hold_left   = 0;
   logic       hold_go     = 1'b0;
   logic       hold_done   = 1'b0;
   logic       calm_tail   = 1'b0;

   calendar_tick_clock u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial forever #1 clock = ~clock;

   // Advance the local calendar by one transaction and return the time it should report.
   function automatic rsp_type predict_step(input req_type item);
      int   n_hund;
      int   n_sec;
      int   n_min;
      int   n_hour;
      int   n_day;
      int   n_month;
      int   n_year;
      int   days;
      logic save_hit;
      save_hit = 1'b0;
      if (item.kind == KIND_LOAD) begin
         clock_now = {item.load_hundredths, item.load_second, item.load_minute,
                      item.load_hour, item.load_day, item.load_month, item.load_year};
      end else begin
         n_hund  = clock_now.hundredths;
         n_sec   = clock_now.second;
         n_min   = clock_now.minute;
         n_hour  = clock_now.hour;
         n_day   = clock_now.day;
         n_month = clock_now.month;
         n_year  = clock_now.year;
         // Compare in full integers: out-of-range fields must carry, not wrap at their width.
         if (n_hund < HUND_LAST) begin
            n_hund++;
         end else begin
            n_hund = 0;
            n_sec++;
            if (n_sec >= SEC_PER_MIN) begin
               n_sec = 0;
               n_min++;
               if (n_min >= MIN_PER_HOUR) begin
                  n_min = 0;
                  n_hour++;
                  if (n_hour >= HOURS_PER_DAY) begin
                     n_hour = 0;
                     n_day++;
                     case (n_month)
                        2: begin
                           days = DAYS_SHORT;
                        end
                        1, 3, 5, 7, 8, 10, 12: begin
                           days = DAYS_LONG;
                        end
                        default: begin
                           days = DAYS_NORMAL;
                        end
                     endcase
                     if (n_day >= days) begin
                        n_day = 0;
                        n_month++;
                        if (n_month > MONTH_LAST) begin
                           n_month = MONTH_FIRST;
                           n_year  = (n_year + 1) & 16'hFFFF;
                        end
                     end
                  end
               end
            end
         end
         clock_now = {7'(n_hund), 6'(n_sec), 6'(n_min), 5'(n_hour), 5'(n_day),
                      4'(n_month), 16'(n_year)};
         save_left = save_left - 8'd1;
         if (save_left == 8'd0) begin
            save_left = save_period;
            save_hit  = 1'b1;
         end
      end
      return {clock_now, save_hit};
   endfunction

   // Driver: offer queued transactions, predict each one as it is accepted.
   always @(posedge clock) begin : drive_requests
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            expected_times.push_back(predict_step(req_data));
         end
         if (!req_valid || taken) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
               send_gap  <= $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure: random bursts plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left <= 60;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
         stall_gap <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest expected time.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_times.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result transaction at cycle %0d", cycle_count);
            end
         end else begin
            want = expected_times.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d: expected y%0d m%0d d%0d %0d:%0d:%0d.%0d save %0b",
                           cycle_count, want.year, want.month, want.day, want.hour,
                           want.minute, want.second, want.hundredths, want.save_request);
                  $display("                       got y%0d m%0d d%0d %0d:%0d:%0d.%0d save %0b",
                           rsp_data.year, rsp_data.month, rsp_data.day, rsp_data.hour,
                           rsp_data.minute, rsp_data.second, rsp_data.hundredths,
                           rsp_data.save_request);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type load_item(input int hund, input int sec, input int mins,
                                         input int hr, input int dy, input int mon,
                                         input int yr);
      req_type item;
      item.kind            = KIND_LOAD;
      item.load_hundredths = 7'(hund);
      item.load_second     = 6'(sec);
      item.load_minute     = 6'(mins);
      item.load_hour       = 5'(hr);
      item.load_day        = 5'(dy);
      item.load_month      = 4'(mon);
      item.load_year       = 16'(yr);
      return item;
   endfunction

   // Tick with random (ignored) load fields.
   function automatic req_type tick_item();
      logic [63:0] raw;
      req_type     item;
      raw       = {$urandom, $urandom};
      item      = raw[49:0];
      item.kind = KIND_TICK;
      return item;
   endfunction

   task automatic push_load_tick(input int hund, input int sec, input int mins, input int hr,
                                 input int dy, input int mon, input int yr);
      pending_reqs.push_back(load_item(hund, sec, mins, hr, dy, mon, yr));
      pending_reqs.push_back(tick_item());
   endtask

   // Mostly ticks; most loads land near a rollover so the ticks after them cascade deep.
   task automatic queue_random(input int count);
      logic [63:0] raw;
      req_type     item;
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            item = tick_item();
         end else if (pick < 93) begin
            item = load_item($urandom_range(92, 99), 59, $urandom_range(58, 59), 23,
                             $urandom_range(27, 30),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 12),
                             ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
         end else if (pick < 97) begin
            raw       = {$urandom, $urandom};
            item      = raw[49:0];
            item.kind = KIND_LOAD;
         end else begin
            item = load_item($urandom_range(0, 99), $urandom_range(0, 59),
                             $urandom_range(0, 59), $urandom_range(0, 23),
                             $urandom_range(0, 30), $urandom_range(1, 12),
                             $urandom_range(0, 65535));
         end
         pending_reqs.push_back(item);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_times.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_interval(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      save_period = value;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_interval[6];
      int phase_items[6];
      phase_interval = '{7, 1, 0, 255, 0, SAVE_INTERVAL_RESET};
      phase_items    = '{100, 60, 400, 330, 60, 60};
      phase_interval[4] = $urandom_range(2, 254);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, month ends, invalid months, out-of-range carries.
      pending_reqs.push_back(tick_item());
      push_load_tick(99, 59, 59, 23, 30, 12, 65535);
      push_load_tick(99, 59, 59, 23, 27, 2, 1999);
      push_load_tick(99, 59, 59, 23, 29, 4, 10);
      push_load_tick(99, 59, 59, 23, 29, 0, 5);
      push_load_tick(99, 59, 59, 23, 29, 13, 7);
      push_load_tick(127, 63, 63, 31, 31, 15, 65535);
      push_load_tick(0, 0, 0, 0, 0, 0, 0);
      push_load_tick(98, 59, 59, 23, 30, 1, 0);
      pending_reqs.push_back(tick_item());
      push_load_tick(99, 58, 59, 23, 0, 6, 0);
      push_load_tick(99, 59, 59, 22, 27, 2, 0);
      push_load_tick(99, 59, 59, 23, 29, 15, 65535);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_interval(8'(phase_interval[p]));
         if (p == 4) begin
            hold_go <= 1'b1;
         end
         if (p == 5) begin
            calm_tail <= 1'b1;
         end
         queue_random(phase_items[p]);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (expected_times.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_times.size());
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
